// File: src/tked_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal key escape decoder package
// Shared types and constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package tked_pkg;

	localparam int MAX_PARAM_DIGITS = 6;

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] TILDE_BYTE = 8'h7E;
	localparam logic [7:0] SEMI_BYTE = 8'h3B;
	localparam logic [7:0] QUEST_BYTE = 8'h3F;
	localparam logic [7:0] LBRACKET_BYTE = 8'h5B;
	localparam logic [7:0] SS3_BYTE = 8'h4F;
	localparam logic [7:0] DIGIT0_BYTE = 8'h30;
	localparam logic [7:0] DIGIT9_BYTE = 8'h39;

	localparam logic [7:0] KEY_LEFT = 8'd0;
	localparam logic [7:0] KEY_RIGHT = 8'd1;
	localparam logic [7:0] KEY_UP = 8'd2;
	localparam logic [7:0] KEY_DOWN = 8'd3;
	localparam logic [7:0] KEY_DEL = 8'd4;
	localparam logic [7:0] KEY_LINE_HOME = 8'd5;
	localparam logic [7:0] KEY_END = 8'd6;
	localparam logic [7:0] KEY_PGUP = 8'd7;
	localparam logic [7:0] KEY_PGDN = 8'd8;
	localparam logic [7:0] KEY_PASTE = 8'd9;
	localparam logic [7:0] KEY_PASTE_END = 8'd10;
	localparam logic [7:0] KEY_NONE = 8'hFF;

	localparam logic [19:0] PARAM_PASTE = 20'd200;
	localparam logic [19:0] PARAM_PASTE_END = 20'd201;

	localparam logic [2:0] DIGITS_SAT = 3'd7;
	localparam logic [7:0] TICKS_SAT = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ESC  = 3'd1,
		PH_CSI  = 3'd2,
		PH_NUM  = 3'd3,
		PH_SKIP = 3'd4,
		PH_PRIV = 3'd5,
		PH_SS3  = 3'd6
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [19:0] param;
		logic [2:0]  digits;
		logic [7:0]  ticks;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] key;
		logic       special;
	} dec_result_t;

endpackage
`default_nettype wire

// File: src/tked_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal key escape decoder step logic
// Computes the next parser state and the optional key for one word.
// ----------------------------------------------------------------------------
module tked_core (
	input  tked_pkg::dec_state_t  cur,
	input  logic                  mode,
	input  logic [7:0]            data_byte,
	input  logic [7:0]            timeout,
	output tked_pkg::dec_state_t  nxt,
	output tked_pkg::dec_result_t res
);

	function automatic tked_pkg::dec_result_t key_or_esc(input logic [7:0] k);
		tked_pkg::dec_result_t r;
		r.valid = 1'b1;
		if (k == tked_pkg::KEY_NONE) begin
			r.key = tked_pkg::ESC_BYTE;
			r.special = 1'b0;
		end else begin
			r.key = k;
			r.special = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [7:0] csi_final(input logic [7:0] b);
		logic [7:0] k;
		unique case (b)
			8'h41: k = tked_pkg::KEY_UP;
			8'h42: k = tked_pkg::KEY_DOWN;
			8'h43: k = tked_pkg::KEY_RIGHT;
			8'h44: k = tked_pkg::KEY_LEFT;
			8'h48: k = tked_pkg::KEY_LINE_HOME;
			8'h46: k = tked_pkg::KEY_END;
			default: k = tked_pkg::KEY_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] tilde_key(input logic [19:0] p);
		logic [7:0] k;
		unique case (p)
			20'd1: k = tked_pkg::KEY_LINE_HOME;
			20'd3: k = tked_pkg::KEY_DEL;
			20'd4: k = tked_pkg::KEY_END;
			20'd5: k = tked_pkg::KEY_PGUP;
			20'd6: k = tked_pkg::KEY_PGDN;
			20'd7: k = tked_pkg::KEY_LINE_HOME;
			20'd8: k = tked_pkg::KEY_END;
			tked_pkg::PARAM_PASTE: k = tked_pkg::KEY_PASTE;
			tked_pkg::PARAM_PASTE_END: k = tked_pkg::KEY_PASTE_END;
			default: k = tked_pkg::KEY_NONE;
		endcase
		return k;
	endfunction

	logic        is_digit;
	logic [3:0]  digit_val;
	logic [7:0]  limit;
	logic [19:0] param_next;

	assign is_digit = (data_byte >= tked_pkg::DIGIT0_BYTE) &&
		(data_byte <= tked_pkg::DIGIT9_BYTE);
	assign digit_val = 4'(data_byte - tked_pkg::DIGIT0_BYTE);
	assign limit = (timeout == 8'd0) ? 8'd1 : timeout;
	assign param_next = {cur.param[16:0], 3'b000} + {cur.param[18:0], 1'b0} +
		20'(digit_val);

	always_comb begin
		nxt = cur;
		res = '0;
		if (mode) begin
			if (cur.phase != tked_pkg::PH_IDLE) begin
				if (cur.ticks != tked_pkg::TICKS_SAT) begin
					nxt.ticks = cur.ticks + 8'd1;
				end
				if (nxt.ticks >= limit) begin
					nxt.phase = tked_pkg::PH_IDLE;
					res = key_or_esc(tked_pkg::KEY_NONE);
				end
			end
		end else begin
			nxt.ticks = '0;
			unique case (cur.phase)
				tked_pkg::PH_IDLE: begin
					if (data_byte == tked_pkg::ESC_BYTE) begin
						nxt.phase = tked_pkg::PH_ESC;
					end else begin
						res.valid = 1'b1;
						res.key = data_byte;
						res.special = 1'b0;
					end
				end
				tked_pkg::PH_ESC: begin
					if (data_byte == tked_pkg::LBRACKET_BYTE) begin
						nxt.phase = tked_pkg::PH_CSI;
					end else if (data_byte == tked_pkg::SS3_BYTE) begin
						nxt.phase = tked_pkg::PH_SS3;
					end else begin
						nxt.phase = tked_pkg::PH_IDLE;
						res = key_or_esc(tked_pkg::KEY_NONE);
					end
				end
				tked_pkg::PH_CSI: begin
					if (is_digit) begin
						nxt.param = 20'(digit_val);
						nxt.digits = 3'd1;
						nxt.phase = tked_pkg::PH_NUM;
					end else if (data_byte == tked_pkg::QUEST_BYTE) begin
						nxt.phase = tked_pkg::PH_PRIV;
					end else begin
						nxt.phase = tked_pkg::PH_IDLE;
						res = key_or_esc(csi_final(data_byte));
					end
				end
				tked_pkg::PH_NUM: begin
					if (is_digit) begin
						if (cur.digits < 3'(tked_pkg::MAX_PARAM_DIGITS)) begin
							nxt.param = param_next;
						end
						if (cur.digits != tked_pkg::DIGITS_SAT) begin
							nxt.digits = cur.digits + 3'd1;
						end
					end else if (data_byte == tked_pkg::TILDE_BYTE) begin
						nxt.phase = tked_pkg::PH_IDLE;
						res = key_or_esc(tilde_key(cur.param));
					end else if (data_byte == tked_pkg::SEMI_BYTE) begin
						nxt.phase = tked_pkg::PH_SKIP;
					end else begin
						nxt.phase = tked_pkg::PH_IDLE;
						res = key_or_esc(csi_final(data_byte));
					end
				end
				tked_pkg::PH_SKIP: begin
					if (!(is_digit || data_byte == tked_pkg::SEMI_BYTE)) begin
						nxt.phase = tked_pkg::PH_IDLE;
						res = key_or_esc(csi_final(data_byte));
					end
				end
				tked_pkg::PH_PRIV: begin
					if (!(is_digit || data_byte == tked_pkg::SEMI_BYTE ||
						data_byte == tked_pkg::QUEST_BYTE)) begin
						nxt.phase = tked_pkg::PH_IDLE;
						res = key_or_esc(tked_pkg::KEY_NONE);
					end
				end
				tked_pkg::PH_SS3: begin
					nxt.phase = tked_pkg::PH_IDLE;
					if (data_byte == 8'h48) begin
						res = key_or_esc(tked_pkg::KEY_LINE_HOME);
					end else if (data_byte == 8'h46) begin
						res = key_or_esc(tked_pkg::KEY_END);
					end else begin
						res = key_or_esc(tked_pkg::KEY_NONE);
					end
				end
				default: begin
					nxt.phase = tked_pkg::PH_IDLE;
					res.valid = 1'b1;
					res.key = data_byte;
					res.special = 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/terminal_key_escape_decoder_unit.sv
// The decoder takes one word per cycle while results are taken and gives its
// key, if any, after acceptance through the input register and then the result
// register. The whole parser step for a word is a single pass of logic
// between those two registers, so a new word can follow in every cycle as
// long as results are taken. The timeout register is always ready.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal key escape decoder
// Turns terminal bytes and timer ticks into plain bytes and special keys.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] key_value,
	output logic       is_special,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	tked_pkg::dec_state_t  state_q;
	tked_pkg::dec_state_t  state_nxt;
	tked_pkg::dec_result_t res;

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic [7:0] timeout_q;
	logic       out_valid_q;
	logic [7:0] key_q;
	logic       special_q;
	logic       advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	tked_core u_core (
		.cur       (state_q),
		.mode      (mode_s1),
		.data_byte (byte_s1),
		.timeout   (timeout_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: tked_pkg::PH_IDLE, param: '0, digits: '0, ticks: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			key_q <= res.key;
			special_q <= res.special;
		end
	end

	assign out_valid = out_valid_q;
	assign key_value = key_q;
	assign is_special = special_q;

endmodule
`default_nettype wire
